// ----- rtl/ihex_pkg.sv -----
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared sizes, the record descriptor passed from front to back, and
// the ASCII codes used in the Intel HEX text.
// ----------------------------------------------------------------------------
package ihex_pkg;

	localparam int MEM_BYTES    = 4096;
	localparam int RECORD_BYTES = 32;

	localparam int ADDR_W = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
	// wide enough for MEM_BYTES itself at its largest value
	localparam int REM_W  = 17;

	// queue between front and back, depth is a power of two
	localparam int QPTR_W      = 1;
	localparam int QUEUE_DEPTH = 1 << QPTR_W;

	localparam logic [6:0] CH_COLON = 7'h3A;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_ONE   = 7'h31;
	localparam logic [6:0] CH_F     = 7'h46;
	localparam logic [6:0] CH_SEVEN = 7'h37;
	localparam logic [6:0] CH_CR    = 7'h0D;
	localparam logic [6:0] CH_LF    = 7'h0A;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic [7:0]  rec_len;
		logic [15:0] a16;
		logic [7:0]  chk;
		logic        rec_last;
		logic        mem_last;
	} ihex_desc_t;

endpackage

// ----- rtl/ihex_front.sv -----
// ----------------------------------------------------------------------------
// ihex_front
// Tracks the byte address and record checksum, classifies each incoming
// byte and pushes one descriptor per byte into the queue.
// ----------------------------------------------------------------------------
module ihex_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                q_full,
	output logic                q_push,
	output ihex_pkg::ihex_desc_t q_desc
);
	import ihex_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] rec_start_q;
	logic [7:0]        off_q;
	logic [7:0]        sum_q;

	logic [REM_W-1:0]  remain;
	logic [7:0]        rec_len;
	logic [15:0]       a16;
	logic              first;
	logic              mem_last;
	logic              rec_last;
	logic [7:0]        sum_base;
	logic [7:0]        sum_new;

	always_comb begin
		remain   = REM_W'(MEM_BYTES) - REM_W'(rec_start_q);
		rec_len  = (remain < REM_W'(RECORD_BYTES)) ? remain[7:0] : 8'(RECORD_BYTES);
		a16      = 16'(rec_start_q);
		first    = (off_q == 8'd0);
		mem_last = (addr_q == ADDR_W'(MEM_BYTES - 1));
		rec_last = ({1'b0, off_q} + 9'd1 >= {1'b0, rec_len}) || mem_last;
		sum_base = first ? (rec_len + a16[15:8] + a16[7:0]) : sum_q;
		sum_new  = sum_base + data_byte;
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		q_desc.data     = data_byte;
		q_desc.first    = first;
		q_desc.rec_len  = rec_len;
		q_desc.a16      = a16;
		q_desc.chk      = ~sum_new + 8'd1;
		q_desc.rec_last = rec_last;
		q_desc.mem_last = mem_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			rec_start_q <= '0;
			off_q       <= '0;
			sum_q       <= '0;
		end else if (q_push) begin
			if (mem_last) begin
				// wrap to a fresh image
				addr_q      <= '0;
				rec_start_q <= '0;
				off_q       <= '0;
				sum_q       <= '0;
			end else if (rec_last) begin
				addr_q      <= addr_q + 1'b1;
				rec_start_q <= addr_q + 1'b1;
				off_q       <= '0;
				sum_q       <= '0;
			end else begin
				addr_q <= addr_q + 1'b1;
				off_q  <= off_q + 8'd1;
				sum_q  <= sum_new;
			end
		end
	end

endmodule

// ----- rtl/ihex_fifo.sv -----
// ----------------------------------------------------------------------------
// ihex_fifo
// Short descriptor queue decoupling the front from the character sequencer.
// ----------------------------------------------------------------------------
module ihex_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ihex_pkg::ihex_desc_t wr_desc,
	output logic                 full,
	input  logic                 pop,
	output ihex_pkg::ihex_desc_t rd_desc,
	output logic                 not_empty
);
	import ihex_pkg::*;

	ihex_desc_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_desc   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/ihex_back.sv -----
// ----------------------------------------------------------------------------
// ihex_back
// Character sequencer: walks header, data digits, checksum and end-of-file
// segments for the descriptor at the queue head, one character per cycle
// while the queue holds a descriptor and the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ihex_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ihex_pkg::ihex_desc_t head,
	input  logic                 head_valid,
	output logic                 pop,
	output logic [6:0]           out_char,
	output logic                 last,
	output logic                 file_done,
	output logic                 out_valid,
	input  logic                 out_ready
);
	import ihex_pkg::*;

	typedef enum logic [1:0] {
		PH_HDR,
		PH_DATA,
		PH_CHK,
		PH_EOF
	} phase_t;

	phase_t     phase_q;
	logic [3:0] cnt_q;
	logic       act_q;

	logic [6:0] char_q;
	logic       last_q;
	logic       done_q;
	logic       valid_q;

	phase_t     cur_phase;
	phase_t     nxt_phase;
	logic [3:0] cur_cnt;
	logic       seg_end;
	logic       item_end;
	logic       load;
	logic       step;
	logic [6:0] ch;

	function automatic logic [6:0] hex_digit(input logic [3:0] v);
		return (v < 4'hA) ? (CH_ZERO + 7'(v)) : (CH_SEVEN + 7'(v));
	endfunction

	always_comb begin
		cur_phase = act_q ? phase_q : (head.first ? PH_HDR : PH_DATA);
		cur_cnt   = act_q ? cnt_q : 4'd0;
	end

	always_comb begin
		ch        = CH_ZERO;
		seg_end   = 1'b0;
		nxt_phase = cur_phase;
		item_end  = 1'b0;
		unique case (cur_phase)
			PH_HDR: begin
				unique case (cur_cnt)
					4'd0:    ch = CH_COLON;
					4'd1:    ch = hex_digit(head.rec_len[7:4]);
					4'd2:    ch = hex_digit(head.rec_len[3:0]);
					4'd3:    ch = hex_digit(head.a16[15:12]);
					4'd4:    ch = hex_digit(head.a16[11:8]);
					4'd5:    ch = hex_digit(head.a16[7:4]);
					4'd6:    ch = hex_digit(head.a16[3:0]);
					default: ch = CH_ZERO;
				endcase
				seg_end   = (cur_cnt == 4'd8);
				nxt_phase = PH_DATA;
			end
			PH_DATA: begin
				ch        = (cur_cnt == 4'd0) ? hex_digit(head.data[7:4])
				                              : hex_digit(head.data[3:0]);
				seg_end   = (cur_cnt == 4'd1);
				nxt_phase = PH_CHK;
				item_end  = seg_end && !head.rec_last;
			end
			PH_CHK: begin
				unique case (cur_cnt)
					4'd0:    ch = hex_digit(head.chk[7:4]);
					4'd1:    ch = hex_digit(head.chk[3:0]);
					4'd2:    ch = CH_CR;
					default: ch = CH_LF;
				endcase
				seg_end   = (cur_cnt == 4'd3);
				nxt_phase = PH_EOF;
				item_end  = seg_end && !head.mem_last;
			end
			PH_EOF: begin
				// ":00000001FF" CR LF
				unique case (cur_cnt)
					4'd0:    ch = CH_COLON;
					4'd8:    ch = CH_ONE;
					4'd9:    ch = CH_F;
					4'd10:   ch = CH_F;
					4'd11:   ch = CH_CR;
					4'd12:   ch = CH_LF;
					default: ch = CH_ZERO;
				endcase
				seg_end   = (cur_cnt == 4'd12);
				item_end  = seg_end;
			end
			default: begin
				ch = CH_ZERO;
			end
		endcase
	end

	assign load = !valid_q || out_ready;
	assign step = head_valid && load;
	assign pop  = step && item_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			cnt_q   <= '0;
			act_q   <= 1'b0;
			valid_q <= 1'b0;
			char_q  <= '0;
			last_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (step) begin
				char_q  <= ch;
				last_q  <= item_end;
				done_q  <= item_end && (cur_phase == PH_EOF);
				valid_q <= 1'b1;
				if (item_end) begin
					act_q <= 1'b0;
				end else if (seg_end) begin
					act_q   <= 1'b1;
					phase_q <= nxt_phase;
					cnt_q   <= '0;
				end else begin
					act_q   <= 1'b1;
					phase_q <= cur_phase;
					cnt_q   <= cur_cnt + 4'd1;
				end
			end else if (load) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_char  = char_q;
	assign last      = last_q;
	assign file_done = done_q;
	assign out_valid = valid_q;

endmodule

// ----- rtl/intel_hex_dump_encoder.sv -----
// ----------------------------------------------------------------------------
// intel_hex_dump_encoder
// Turns a stream of memory bytes into Intel HEX text, one character a cycle when not stalled.
// ----------------------------------------------------------------------------
// Input channel: data_byte with in_valid / in_ready, one memory byte per
// transaction, in ascending address order from zero.
// Output channel: out_char, last, file_done with out_valid / out_ready, one
// ASCII character per transaction. last marks the final character caused by
// a byte; file_done marks the LF ending the end-of-file record.
// A byte inside a record gives 2 characters; a byte opening a record gives 11,
// one closing a record 4 more, and the last memory byte 13 more. The character
// sequencer emits one character per cycle while the receiver keeps out_ready
// high and the queue holds a descriptor, and sets the rate.
// With the queue empty, an accepted byte is written into the queue and its
// first character is then registered in the output stage.
// The front classifies bytes and computes checksums ahead of the sequencer;
// a two-entry queue lets it keep taking bytes while output is stalled.
// When the receiver stalls, the held character stays on the outputs and the
// queue fills, after which in_ready drops. Reset clears the address, the
// checksum, the queue and the output stage; there is no clearing pass.
// ----------------------------------------------------------------------------
module intel_hex_dump_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [6:0] out_char,
	output logic       last,
	output logic       file_done,
	output logic       out_valid,
	input  logic       out_ready
);
	import ihex_pkg::*;

	ihex_desc_t wr_desc;
	ihex_desc_t rd_desc;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_not_empty;

	ihex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (wr_desc)
	);

	ihex_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_desc   (wr_desc),
		.full      (q_full),
		.pop       (q_pop),
		.rd_desc   (rd_desc),
		.not_empty (q_not_empty)
	);

	ihex_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (rd_desc),
		.head_valid (q_not_empty),
		.pop        (q_pop),
		.out_char   (out_char),
		.last       (last),
		.file_done  (file_done),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule
